### rtl/assert_macros.svh
// Assertion macros shared by actr_aes_core and actr_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### rtl/actr_pkg.sv
// -----------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and AES helper functions for the CTR XOR block.
// -----------------------------------------------------------------------------
`default_nettype none
package actr_pkg;
  localparam int QUEUE_DEPTH = 4;
  localparam int BLK_W       = 60;

  localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
  localparam logic [1:0] REG_KEY_LOW   = 2'd1;
  localparam logic [1:0] REG_NONCE     = 2'd2;
  localparam logic [1:0] REG_CIPHER_ON = 2'd3;

  // queued byte word between front and back
  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [3:0]       sel;
    logic [7:0]       data;
    logic             last;
    logic             enc;
  } item_t;

  // AES core request: start strobe and block number
  typedef struct packed {
    logic             start;
    logic [BLK_W-1:0] blk;
  } aes_req_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit state, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // one round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        t[j+4*c] = sbox(byte_of(s, j + 4*((c+j) & 3)));
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o ^ rk;
  endfunction

  // next round key from the current one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0]  w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction
endpackage
`default_nettype wire

### rtl/aes128_ctr_offset_keystream_xor.sv
// -----------------------------------------------------------------------------
// aes128_ctr_offset_keystream_xor
// AES-128-CTR keystream XOR of a byte stream addressed by absolute offset.
// -----------------------------------------------------------------------------
// Usage:
//   in_*  : stream of bytes; tdata = {data_byte, byte_offset}, packed as
//           byte_offset[63:0], data_byte[71:64]; tlast = last_of_run.
//   out_* : one word per input word; tdata = out_byte, tlast = out_last.
//   cfg_* : register writes (0 key_high, 1 key_low, 2 nonce, 3 cipher_on),
//           only while idle. Key or nonce writes drop the cached block.
// Throughput: one byte per cycle while bytes stay in the cached 16-byte block and
// the receiver is ready. A new block is computed in the round-iterative AES core
// (load, then one round per cycle); the missing byte and those behind it wait.
// On a cache hit a byte passes through the queue and the output buffer registers.
// Reset clears the queue, output buffer and cache valid bit; registers go to 0.
// A stalled receiver fills the output buffer then the queue, then in_tready
// drops; nothing is lost.
// -----------------------------------------------------------------------------
`default_nettype none
module aes128_ctr_offset_keystream_xor import actr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // byte_offset[63:0], data_byte[71:64]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [63:0] kh_r, kl_r, nonce_r;
  logic        on_r, wr, inval, q_valid, q_pop, aes_busy, aes_done;
  item_t       q_item;
  aes_req_t    req;
  logic [127:0] aes_ks;

  assign cfg_ready = 1'b1;
  assign wr    = cfg_valid;
  assign inval = wr && (cfg_index != REG_CIPHER_ON);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r <= '0; kl_r <= '0; nonce_r <= '0; on_r <= 1'b0;
    end else if (wr) begin
      case (cfg_index)
        REG_KEY_HIGH:  kh_r    <= cfg_data;
        REG_KEY_LOW:   kl_r    <= cfg_data;
        REG_NONCE:     nonce_r <= cfg_data;
        REG_CIPHER_ON: on_r    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  actr_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_byte_offset(in_tdata[63:0]), .in_data_byte(in_tdata[71:64]),
    .in_last(in_tlast), .cipher_on(on_r),
    .q_valid, .q_pop, .q_item
  );

  actr_aes_core u_aes (
    .clk, .rst_n, .req, .key({kh_r, kl_r}), .nonce(nonce_r),
    .busy(aes_busy), .done(aes_done), .ks(aes_ks)
  );

  actr_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .inval, .req,
    .aes_busy, .aes_done, .aes_ks,
    .out_tvalid, .out_tready, .out_byte(out_tdata), .out_last(out_tlast)
  );
endmodule
`default_nettype wire

### rtl/actr_front.sv
// -----------------------------------------------------------------------------
// actr_front
// Accepts input bytes, tags them with block number, lane and cipher mode,
// and pushes them into a small queue toward the back end.
// -----------------------------------------------------------------------------
`default_nettype none
module actr_front import actr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_byte_offset,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  input  wire logic        cipher_on,
  output logic             q_valid,
  input  wire logic        q_pop,
  output item_t            q_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push;
  item_t         it;

  assign in_tready = (cnt_r != (AW+1)'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rp_r];

  // classify the incoming byte
  always_comb begin
    it.blk  = in_byte_offset[63:4];
    it.sel  = in_byte_offset[3:0];
    it.data = in_data_byte;
    it.last = in_last;
    it.enc  = cipher_on;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

### rtl/actr_aes_core.sv
// -----------------------------------------------------------------------------
// actr_aes_core
// Round-iterative AES-128 encryption of nonce || block number, one round per
// cycle.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module actr_aes_core import actr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire aes_req_t     req,
  input  wire logic [127:0] key,
  input  wire logic [63:0]  nonce,
  output logic              busy,
  output logic              done,
  output logic [127:0]      ks
);
  logic [127:0] st_r, st_nxt, rk_r, rk_nxt;
  logic [3:0]   rnd_r;
  logic [7:0]   rc_r;
  logic         busy_r, done_r;

  assign busy = busy_r;
  assign done = done_r;
  assign ks   = st_r;

  always_comb begin
    rk_nxt = next_key(rk_r, rc_r);
    st_nxt = aes_round(st_r, rk_nxt, rnd_r != 4'd10);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      st_r <= {nonce, req.blk[59:56] & 4'h0, req.blk} ^ key;
      rk_r <= key;
    end else if (busy_r) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; rnd_r <= 4'd0; rc_r <= 8'h01;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1; rnd_r <= 4'd1; rc_r <= 8'h01;
      end else if (busy_r) begin
        rc_r  <= xt(rc_r);
        rnd_r <= rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end

  `ASSERT_NEVER(a_start_busy, clk, rst_n, req.start && busy_r, "start while busy")
  `ASSERT_CLK(a_done_end, clk, rst_n, busy_r && rnd_r == 4'd10 |=> done_r, "no done")
  `ASSERT_NEVER(a_done_busy, clk, rst_n, done_r && busy_r, "done while busy")
endmodule
`default_nettype wire

### rtl/actr_back.sv
// -----------------------------------------------------------------------------
// actr_back
// Pops queued bytes, refills the keystream cache when an enc byte misses and
// XORs the keystream byte if enc is set; a two-entry skid buffer drives the output.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module actr_back import actr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  output logic              q_pop,
  input  wire item_t        q_item,
  input  wire logic         inval,
  output aes_req_t          req,
  input  wire logic         aes_busy,
  input  wire logic         aes_done,
  input  wire logic [127:0] aes_ks,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  logic [127:0]     ks_r;
  logic [BLK_W-1:0] blk_r;
  logic             cv_r, wait_r;
  logic             hit, can_go;
  logic [7:0]       kbyte, res;
  // output buffer, two slots
  logic [8:0]       ob_r [2];
  logic [1:0]       ocnt_r;
  logic             orp_r, owp_r;

  assign hit    = cv_r && (blk_r == q_item.blk);
  assign can_go = q_valid && !wait_r && !aes_busy && (ocnt_r != 2'd2) &&
                  (!q_item.enc || hit);
  assign q_pop  = can_go;
  assign req.start = q_valid && q_item.enc && !hit && !wait_r && !aes_busy;
  assign req.blk   = q_item.blk;
  assign kbyte  = ks_r[127 - 8*q_item.sel -: 8];
  assign res    = q_item.enc ? (q_item.data ^ kbyte) : q_item.data;

  assign out_tvalid = (ocnt_r != 2'd0);
  assign {out_last, out_byte} = ob_r[orp_r];

  always_ff @(posedge clk) begin
    if (aes_done) begin
      ks_r <= aes_ks; blk_r <= req.blk;
    end
    if (can_go) ob_r[owp_r] <= {q_item.last, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0; wait_r <= 1'b0; ocnt_r <= '0; orp_r <= 1'b0; owp_r <= 1'b0;
    end else begin
      if (req.start) wait_r <= 1'b1;
      if (aes_done) begin
        wait_r <= 1'b0; cv_r <= 1'b1;
      end
      if (inval) cv_r <= 1'b0;
      if (can_go) owp_r <= ~owp_r;
      if (out_tvalid && out_tready) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(can_go) - 2'(out_tvalid && out_tready);
    end
  end

  `ASSERT_NEVER(a_ob_ovf, clk, rst_n, ocnt_r == 2'd3, "output buffer overflow")
  `ASSERT_CLK(a_pop_hit, clk, rst_n, q_pop && q_item.enc |-> hit, "xor without hit")
  `ASSERT_NEVER(a_pop_wait, clk, rst_n, q_pop && wait_r, "pop during refill")
endmodule
`default_nettype wire

### test/aes128_ctr_offset_keystream_xor_chk.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// aes128_ctr_offset_keystream_xor_chk
// Scoreboard for the CTR XOR block. It snoops the config, input and output
// channels and keeps its own register copy and an independent AES-128 model.
// Each accepted input word queues its expected output byte, and each accepted
// output word is compared in order.
// -----------------------------------------------------------------------------
module aes128_ctr_offset_keystream_xor_chk import actr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          err_count,
  output int          pending
);

  typedef struct {
    logic [7:0] plain;
    logic       last;
  } plain_word_t;

  plain_word_t plain_q[$];

  logic [63:0] key_hi, key_lo, ctr_nonce;
  logic        xor_en;
  logic [7:0]  sb_tab [256];

  // GF(2^8) multiply, AES polynomial
  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box built from the field inverse and the affine map
  initial begin
    logic [7:0] inv;
    for (int b = 0; b < 256; b++) begin
      inv = 8'h00;
      if (b != 0) begin
        inv = 8'h01;
        for (int k = 0; k < 254; k++) inv = gmul(inv, b[7:0]);
      end
      sb_tab[b] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  // AES-128 encryption, byte 0 in the top bits of key, block and result
  function automatic logic [127:0] encipher(logic [127:0] key, logic [127:0] blk);
    logic [31:0]  w [44];
    logic [31:0]  tw;
    logic [7:0]   rc;
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] rk, res;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      tw = w[i-1];
      if (i % 4 == 0) begin
        tw = {sb_tab[tw[23:16]] ^ rc, sb_tab[tw[15:8]], sb_tab[tw[7:0]], sb_tab[tw[31:24]]};
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ tw;
    end
    rk = {w[0], w[1], w[2], w[3]};
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      // SubBytes and ShiftRows
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          t[row+4*c] = sb_tab[s[row + 4*((c+row) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          t[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
          t[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
          t[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
        end
      end
      rk = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  // expected output byte for one input word
  function automatic logic [7:0] decrypt_byte(logic [63:0] pos, logic [7:0] data);
    logic [127:0] ks;
    if (!xor_en) return data;
    ks = encipher({key_hi, key_lo}, {ctr_nonce, 4'h0, pos[63:4]});
    return data ^ ks[127-8*pos[3:0] -: 8];
  endfunction

  always @(posedge clk) begin
    plain_word_t exp_w;
    int          n_err;
    n_err = 0;
    if (!rst_n) begin
      key_hi <= '0; key_lo <= '0; ctr_nonce <= '0; xor_en <= 1'b0;
      plain_q.delete();
      err_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_HIGH:  key_hi    <= cfg_data;
          REG_KEY_LOW:   key_lo    <= cfg_data;
          REG_NONCE:     ctr_nonce <= cfg_data;
          REG_CIPHER_ON: xor_en    <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        exp_w.plain = decrypt_byte(in_tdata[63:0], in_tdata[71:64]);
        exp_w.last  = in_tlast;
        plain_q = {plain_q, exp_w};
      end
      if (out_tvalid && out_tready) begin
        if (plain_q.size() == 0) begin
          $error("unexpected output word: out_byte %h out_last %b", out_tdata, out_tlast);
          n_err++;
        end else begin
          exp_w = plain_q.pop_front();
          if (out_tdata !== exp_w.plain) begin
            $error("out_byte mismatch: expected %h actual %h", exp_w.plain, out_tdata);
            n_err++;
          end
          if (out_tlast !== exp_w.last) begin
            $error("out_last mismatch: expected %b actual %b", exp_w.last, out_tlast);
            n_err++;
          end
        end
      end
      err_count <= err_count + n_err;
      pending <= plain_q.size();
    end
  end

endmodule

### test/aes128_ctr_offset_keystream_xor_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// aes128_ctr_offset_keystream_xor_tb
// Stimulus for the CTR XOR block: directed extremes of offset, data, key and
// nonce, then random single bytes and runs of consecutive offsets under changing keys, with
// random gaps on the input side and random stalls on the output side.
// -----------------------------------------------------------------------------
module aes128_ctr_offset_keystream_xor_tb;
  import actr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          err_count;
  int          pending;
  bit          no_gaps = 1'b0;
  int          stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aes128_ctr_offset_keystream_xor dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  aes128_ctr_offset_keystream_xor_chk chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .err_count, .pending
  );

  // receiver: random stalls between words
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        if (!no_gaps && $urandom_range(1, 0)) begin
          stall_left <= $urandom_range(5, 1) - 1;
          out_tready <= 1'b0;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one register write, only once every output word has drained
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(logic [63:0] kh, logic [63:0] kl, logic [63:0] nc, logic on);
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_NONCE, nc);
    write_reg(REG_CIPHER_ON, {63'd0, on});
  endtask

  // one byte word; valid stays high across back-to-back words
  task automatic send_byte(logic [63:0] pos, logic [7:0] data, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(5, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {data, pos};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_run(logic [63:0] start, int len);
    for (int i = 0; i < len; i++)
      send_byte(start + i, 8'($urandom), i == len - 1);
  endtask

  initial begin
    logic [63:0] pos;
    int          sent;
    int          len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through with cipher off
    send_byte(64'h0, 8'h00, 1'b0);
    send_byte(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1);
    send_byte(64'h1234_5678_9ABC_DEF0, 8'h5A, 1'b0);
    in_tvalid <= 1'b0;

    // all-zero key and nonce, block edges and the top offset
    load_key('0, '0, '0, 1'b1);
    send_byte(64'd0, 8'h00, 1'b0);
    send_byte(64'd15, 8'hFF, 1'b0);
    send_byte(64'd16, 8'hA5, 1'b0);
    send_byte(64'hFFFF_FFFF_FFFF_FFF0, 8'h00, 1'b0);
    send_byte(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1);
    in_tvalid <= 1'b0;

    // all-ones key and nonce; same offsets must reload the cached block
    load_key('1, '1, '1, 1'b1);
    send_byte(64'd0, 8'h00, 1'b0);
    send_byte(64'd15, 8'hFF, 1'b0);
    send_byte(64'hFFFF_FFFF_FFFF_FFFF, 8'h3C, 1'b1);
    in_tvalid <= 1'b0;

    // key low rewritten alone, then nonce alone, at the same offset
    write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    send_byte(64'd7, 8'h11, 1'b1);
    in_tvalid <= 1'b0;
    write_reg(REG_NONCE, 64'h8000_0000_0000_0001);
    send_byte(64'd7, 8'h11, 1'b1);
    send_byte(64'd8, 8'h22, 1'b0);
    in_tvalid <= 1'b0;

    // random runs of consecutive offsets, config changed between phases
    sent = 0;
    while (sent < 1250) begin
      if ($urandom_range(9, 0) == 0)
        load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 $urandom_range(4, 0) != 0);
      no_gaps = ($urandom_range(3, 0) == 0);
      for (int r = 0; r < 8; r++) begin
        case ($urandom_range(3, 0))
          0:       pos = {$urandom, $urandom};
          1:       pos = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(40, 0);
          default: pos = {32'd0, $urandom_range(4096, 0)};
        endcase
        if ($urandom_range(5, 0) == 0) begin
          send_byte(pos, 8'($urandom), 1'($urandom));
          sent++;
        end else begin
          len = $urandom_range(40, 1);
          send_run(pos, len);
          sent += len;
        end
      end
      in_tvalid <= 1'b0;
      while (pending != 0) @(posedge clk);
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
